@@ src/rfb_pkg.sv @@
package rfb_pkg;

  localparam int MOM_W   = 40;
  localparam int ANGLE_W = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_HIGH = 2'd1;

  localparam logic [ANGLE_W-1:0] ANGLE_LOW_RST  = 24'd32768;
  localparam logic [ANGLE_W-1:0] ANGLE_HIGH_RST = 24'd557056;

  localparam logic [1:0] FAULT_NONE = 2'd0;
  localparam logic [1:0] FAULT_ZERO = 2'd1;
  localparam logic [1:0] FAULT_REF  = 2'd2;

  localparam int CORDIC_STEPS = 28;
  localparam logic [63:0] DEG_PER_RAD_Q24 = 64'd961263669;

  typedef struct packed {
    logic signed [MOM_W-1:0] ref_px;
    logic signed [MOM_W-1:0] ref_py;
    logic signed [MOM_W-1:0] ref_pz;
    logic signed [MOM_W-1:0] ref_energy;
    logic signed [MOM_W-1:0] part_px;
    logic signed [MOM_W-1:0] part_py;
    logic signed [MOM_W-1:0] part_pz;
    logic signed [MOM_W-1:0] part_energy;
  } in_item_t;

  typedef struct packed {
    logic signed [MOM_W-1:0] boosted_px;
    logic signed [MOM_W-1:0] boosted_py;
    logic signed [MOM_W-1:0] boosted_pz;
    logic signed [MOM_W-1:0] boosted_energy;
    logic [ANGLE_W-1:0]      polar_angle;
    logic                    in_window;
    logic [1:0]              fault;
  } out_item_t;

  typedef struct packed {
    logic     nonpos_energy;
    in_item_t item;
  } qhead_t;

  // arctangent of 2^-i in Q.24 degrees
  function automatic logic [31:0] atan_step(input logic [4:0] i);
    logic [63:0] v;
    v = '0;
    case (i)
      5'd0:  v = 64'd754974720;
      5'd1:  v = 64'd445687602;
      5'd2:  v = 64'd235489088;
      5'd3:  v = 64'd119537938;
      5'd4:  v = 64'd60000934;
      5'd5:  v = 64'd30029717;
      5'd6:  v = 64'd15018523;
      5'd7:  v = 64'd7509720;
      5'd8:  v = 64'd3754917;
      5'd9:  v = 64'd1877466;
      5'd10: v = 64'd938734;
      5'd11: v = 64'd469367;
      default: v = (DEG_PER_RAD_Q24 + (64'd1 << (i - 5'd1))) >> i;
    endcase
    return v[31:0];
  endfunction

endpackage

@@ src/rfb_ifs.sv @@
interface rfb_in_if;
  import rfb_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface rfb_out_if;
  import rfb_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ src/rest_frame_boost_angle_cut.sv @@
// Rest-frame boost with polar-angle window.
// item_in carries a reference and a particle four-momentum (signed Q23.16);
// result_out returns the boosted four-momentum, the polar angle to +z in
// Q8.16 degrees, the window flag and a fault code, one result per item.
// Both channels move an item when valid and ready are high at a clock edge.
// The window edges are written on cfg_we with cfg_index 0 (low) or 1 (high).
// Items enter a queue of QUEUE_DEPTH entries, so the source keeps sending
// while the engine works and while a finished result waits to be taken.
// In the engine, fifteen 8-bit-digit multiplies, two square roots, four
// 128-step divisions, normalization and 28 CORDIC steps share one
// sequencer; the bit-serial divider dominates.
// A reference with no positive energy is flagged as it is queued and
// goes straight to the output without engine work.
// Throughput is one item per engine pass.
// Reset empties the queue, drops any result and restores the window to
// 0.5 .. 8.5 degrees. A stalled receiver holds the result in the output
// register; the engine then waits and the queue fills until ready drops.
module rest_frame_boost_angle_cut #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  rfb_in_if.sink                        item_in,
  rfb_out_if.source                     result_out,
  input  logic                          cfg_we,
  input  logic [rfb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rfb_pkg::ANGLE_W-1:0]   cfg_data
);
  import rfb_pkg::*;

  logic [ANGLE_W-1:0] angle_low;
  logic [ANGLE_W-1:0] angle_high;
  logic               head_valid;
  qhead_t             head;
  logic               pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      angle_low <= ANGLE_LOW_RST;
      angle_high <= ANGLE_HIGH_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ANGLE_LOW:  angle_low <= cfg_data;
        CFG_ANGLE_HIGH: angle_high <= cfg_data;
        default: ;
      endcase
    end
  end

  rfb_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  rfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .angle_low  (angle_low),
    .angle_high (angle_high),
    .result_out (result_out)
  );

endmodule

@@ src/rfb_front.sv @@
module rfb_front #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  rfb_in_if.sink          item_in,
  output logic            head_valid,
  output rfb_pkg::qhead_t head,
  input  logic            pop
);
  import rfb_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  qhead_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               take;
  qhead_t             entry;

  assign item_in.ready = (count < CNT_W'(DEPTH));
  assign push = item_in.valid && item_in.ready;
  assign take = pop && head_valid;
  assign head_valid = (count != '0);
  assign head = mem[rd_ptr];

  // classify while queueing: a reference with no positive energy is never timelike
  always_comb begin
    entry.item = item_in.payload;
    entry.nonpos_energy = (item_in.payload.ref_energy <= 0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !take) begin
        count <= count + 1'b1;
      end else if (take && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/rfb_mul.sv @@
module rfb_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [82:0]  a,
  input  logic signed [40:0]  b,
  output logic                done,
  output logic signed [127:0] prod
);

  logic [81:0]  ma;
  logic [47:0]  mb;
  logic [127:0] acc;
  logic         neg;
  logic [2:0]   cnt;
  logic [89:0]  pp;
  logic [82:0]  a_mag;
  logic [40:0]  b_mag;

  assign pp = ma * mb[47:40];
  assign a_mag = a[82] ? 83'(-a) : 83'(a);
  assign b_mag = b[40] ? 41'(-b) : 41'(b);

  // eight multiplier bits per cycle, top digit first
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ma <= a_mag[81:0];
        mb <= {7'b0, b_mag};
        neg <= a[82] ^ b[40];
        acc <= '0;
        cnt <= 3'd7;
      end else if (cnt > 3'd1) begin
        acc <= (acc << 8) + {38'b0, pp};
        mb <= mb << 8;
        cnt <= cnt - 1'b1;
      end else if (cnt == 3'd1) begin
        prod <= neg ? $signed(-acc) : $signed(acc);
        done <= 1'b1;
        cnt <= '0;
      end
    end
  end

endmodule

@@ src/rfb_div.sv @@
module rfb_div (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [127:0] n,
  input  logic [81:0]  d,
  output logic         done,
  output logic [127:0] quo
);

  logic [127:0] num;
  logic [82:0]  den2;
  logic [83:0]  rem;
  logic [83:0]  rs;
  logic [7:0]   cnt;

  assign rs = {rem[82:0], num[127]};

  // rounds to nearest: floor((2n + d) / 2d), one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        num <= (n << 1) + {46'b0, d};
        den2 <= {d, 1'b0};
        rem <= '0;
        quo <= '0;
        cnt <= 8'd128;
      end else if (cnt != '0) begin
        if (rs >= {1'b0, den2}) begin
          rem <= rs - {1'b0, den2};
          quo <= {quo[126:0], 1'b1};
        end else begin
          rem <= rs;
          quo <= {quo[126:0], 1'b0};
        end
        num <= num << 1;
        cnt <= cnt - 1'b1;
        if (cnt == 8'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/rfb_sqrt.sv @@
module rfb_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [81:0] x,
  output logic        done,
  output logic [40:0] root
);

  logic [81:0] xs;
  logic [43:0] rem;
  logic [43:0] rs;
  logic [43:0] trial;
  logic [5:0]  cnt;

  assign rs = {rem[41:0], xs[81:80]};
  assign trial = {1'b0, root, 2'b01};

  // two radicand bits per cycle, result rounded down
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        xs <= x;
        rem <= '0;
        root <= '0;
        cnt <= 6'd41;
      end else if (cnt != '0) begin
        if (rs >= trial) begin
          rem <= rs - trial;
          root <= {root[39:0], 1'b1};
        end else begin
          rem <= rs;
          root <= {root[39:0], 1'b0};
        end
        xs <= xs << 2;
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/rfb_back.sv @@
module rfb_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       head_valid,
  input  rfb_pkg::qhead_t            head,
  output logic                       pop,
  input  logic [rfb_pkg::ANGLE_W-1:0] angle_low,
  input  logic [rfb_pkg::ANGLE_W-1:0] angle_high,
  rfb_out_if.source                  result_out
);
  import rfb_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE      = 11'b00000000001,
    ST_MUL_GO    = 11'b00000000010,
    ST_MUL_WAIT  = 11'b00000000100,
    ST_SQRT_GO   = 11'b00000001000,
    ST_SQRT_WAIT = 11'b00000010000,
    ST_DIV_GO    = 11'b00000100000,
    ST_DIV_WAIT  = 11'b00001000000,
    ST_NORM      = 11'b00010000000,
    ST_CORD      = 11'b00100000000,
    ST_ANG       = 11'b01000000000,
    ST_OUT       = 11'b10000000000
  } state_t;

  localparam logic [3:0] K_E2  = 4'd0;
  localparam logic [3:0] K_PX2 = 4'd1;
  localparam logic [3:0] K_PY2 = 4'd2;
  localparam logic [3:0] K_PZ2 = 4'd3;
  localparam logic [3:0] K_DX  = 4'd4;
  localparam logic [3:0] K_DY  = 4'd5;
  localparam logic [3:0] K_DZ  = 4'd6;
  localparam logic [3:0] K_EEM = 4'd7;
  localparam logic [3:0] K_DEN = 4'd8;
  localparam logic [3:0] K_EE  = 4'd9;
  localparam logic [3:0] K_BX  = 4'd10;
  localparam logic [3:0] K_BY  = 4'd11;
  localparam logic [3:0] K_BZ  = 4'd12;
  localparam logic [3:0] K_RX  = 4'd13;
  localparam logic [3:0] K_RY  = 4'd14;

  localparam logic signed [43:0] B_MAX = 44'sd549755813887;
  localparam logic signed [43:0] B_MIN = -44'sd549755813888;
  localparam logic [127:0] T_LIM = 128'd1 << 41;
  localparam logic [127:0] E_POS = (128'd1 << 39) - 128'd1;
  localparam logic [127:0] E_NEG = 128'd1 << 39;
  localparam logic [63:0]  NORM_LIM = 64'd1 << 58;
  localparam logic signed [33:0] ACC_MAX = 34'sd180 <<< 24;
  localparam logic signed [33:0] ACC_RIGHT = 34'sd90 <<< 24;

  state_t st;
  logic [3:0] k;
  logic sq_rho;
  logic div_e;

  logic signed [39:0] p [3];
  logic signed [39:0] q [3];
  logic signed [39:0] en;
  logic signed [39:0] ee;
  logic signed [39:0] bv [3];
  logic [79:0]        e2;
  logic [80:0]        p2;
  logic [80:0]        p2_sum;
  logic [39:0]        m;
  logic [40:0]        em;
  logic signed [81:0] d;
  logic signed [82:0] a;
  logic [79:0]        den;
  logic signed [81:0] nn;
  logic [79:0]        r2;
  logic [127:0]       dn;
  logic [81:0]        dd;
  logic               nneg;
  logic [63:0]        ux;
  logic [63:0]        uy;
  logic [63:0]        mx;
  logic signed [63:0] cx;
  logic signed [63:0] cy;
  logic signed [33:0] acc;
  logic [4:0]         ci;
  out_item_t          res;

  logic               mul_start;
  logic               mul_done;
  logic signed [82:0] mul_a;
  logic signed [40:0] mul_b;
  logic signed [127:0] prod;
  logic [127:0]       prod_mag;
  logic               sqrt_start;
  logic               sqrt_done;
  logic [81:0]        sqrt_x;
  logic [40:0]        root;
  logic               div_start;
  logic               div_done;
  logic [127:0]       quo;

  logic [41:0]        t_mag;
  logic signed [43:0] t_sig;
  logic signed [43:0] b_sum;
  logic signed [39:0] b_new;
  logic signed [39:0] be_new;
  logic [80:0]        nn_mag;
  logic signed [63:0] cdx;
  logic signed [63:0] cdy;
  logic [31:0]        atan_v;
  logic signed [33:0] acc_c;
  logic [33:0]        acc_r;
  logic [23:0]        angle;

  assign mul_start = (st == ST_MUL_GO);
  assign sqrt_start = (st == ST_SQRT_GO);
  assign div_start = (st == ST_DIV_GO);
  assign pop = (st == ST_IDLE) && head_valid;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (k)
      K_E2:  begin mul_a = 83'(en);   mul_b = 41'(en);   end
      K_PX2: begin mul_a = 83'(p[0]); mul_b = 41'(p[0]); end
      K_PY2: begin mul_a = 83'(p[1]); mul_b = 41'(p[1]); end
      K_PZ2: begin mul_a = 83'(p[2]); mul_b = 41'(p[2]); end
      K_DX:  begin mul_a = 83'(p[0]); mul_b = 41'(q[0]); end
      K_DY:  begin mul_a = 83'(p[1]); mul_b = 41'(q[1]); end
      K_DZ:  begin mul_a = 83'(p[2]); mul_b = 41'(q[2]); end
      K_EEM: begin mul_a = 83'(ee);   mul_b = $signed(em); end
      K_DEN: begin mul_a = $signed({43'b0, m}); mul_b = $signed(em); end
      K_EE:  begin mul_a = 83'(en);   mul_b = 41'(ee);   end
      K_BX:  begin mul_a = a;         mul_b = 41'(p[0]); end
      K_BY:  begin mul_a = a;         mul_b = 41'(p[1]); end
      K_BZ:  begin mul_a = a;         mul_b = 41'(p[2]); end
      K_RX:  begin mul_a = 83'(bv[0]); mul_b = 41'(bv[0]); end
      K_RY:  begin mul_a = 83'(bv[1]); mul_b = 41'(bv[1]); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign sqrt_x = sq_rho ? {2'b0, r2} : ({2'b0, e2} - {1'b0, p2});
  assign prod_mag = prod[127] ? $unsigned(-prod) : $unsigned(prod);
  assign p2_sum = p2 + prod[80:0];
  assign nn_mag = nn[81] ? 81'(-nn) : 81'(nn);

  rfb_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  rfb_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (root)
  );

  rfb_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .n     (dn),
    .d     (dd),
    .done  (div_done),
    .quo   (quo)
  );

  // momentum correction limited, then added and saturated; boosted energy clamped
  always_comb begin
    t_mag = (quo > T_LIM) ? T_LIM[41:0] : quo[41:0];
    t_sig = nneg ? -$signed({2'b0, t_mag}) : $signed({2'b0, t_mag});
    b_sum = 44'(q[0]);
    case (k)
      K_BY: b_sum = 44'(q[1]);
      K_BZ: b_sum = 44'(q[2]);
      default: b_sum = 44'(q[0]);
    endcase
    b_sum = b_sum + t_sig;
    if (b_sum > B_MAX) begin
      b_new = B_MAX[39:0];
    end else if (b_sum < B_MIN) begin
      b_new = B_MIN[39:0];
    end else begin
      b_new = b_sum[39:0];
    end
    if (nneg) begin
      be_new = (quo > E_NEG) ? -$signed(E_NEG[39:0]) : -$signed(quo[39:0]);
    end else begin
      be_new = (quo > E_POS) ? $signed(E_POS[39:0]) : $signed(quo[39:0]);
    end
  end

  always_comb begin
    mx = (ux > uy) ? ux : uy;
    cdx = cy >>> ci;
    cdy = cx >>> ci;
    atan_v = atan_step(ci);
    if (acc < 0) begin
      acc_c = '0;
    end else if (acc > ACC_MAX) begin
      acc_c = ACC_MAX;
    end else begin
      acc_c = acc;
    end
    acc_r = ($unsigned(acc_c) + 34'd128) >> 8;
    angle = acc_r[23:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      k <= K_E2;
      sq_rho <= 1'b0;
      div_e <= 1'b0;
      ci <= '0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (head_valid) begin
            p[0] <= head.item.ref_px;
            p[1] <= head.item.ref_py;
            p[2] <= head.item.ref_pz;
            en <= head.item.ref_energy;
            q[0] <= head.item.part_px;
            q[1] <= head.item.part_py;
            q[2] <= head.item.part_pz;
            ee <= head.item.part_energy;
            k <= K_E2;
            sq_rho <= 1'b0;
            div_e <= 1'b0;
            if (head.nonpos_energy) begin
              res <= out_item_t'({{($bits(out_item_t) - 2){1'b0}}, FAULT_REF});
              st <= ST_OUT;
            end else begin
              res <= '0;
              st <= ST_MUL_GO;
            end
          end
        end
        ST_MUL_GO: st <= ST_MUL_WAIT;
        ST_MUL_WAIT: begin
          if (mul_done) begin
            case (k)
              K_E2:  e2 <= prod[79:0];
              K_PX2: p2 <= prod[80:0];
              K_PY2: p2 <= p2_sum;
              K_PZ2: p2 <= p2_sum;
              K_DX:  d <= prod[81:0];
              K_DY:  d <= d + prod[81:0];
              K_DZ:  d <= d + prod[81:0];
              K_EEM: a <= 83'(d) - prod[82:0];
              K_DEN: den <= prod[79:0];
              K_EE:  nn <= prod[81:0] - d;
              K_BX, K_BY, K_BZ: begin
                nneg <= prod[127];
                dn <= prod_mag;
                dd <= {2'b0, den};
              end
              K_RX:  r2 <= prod[79:0];
              K_RY: begin
                r2 <= r2 + prod[79:0];
                sq_rho <= 1'b1;
              end
              default: ;
            endcase
            if (k == K_BX || k == K_BY || k == K_BZ) begin
              st <= ST_DIV_GO;
            end else if (k == K_PZ2) begin
              k <= k + 1'b1;
              if ({1'b0, e2} <= p2_sum) begin
                res.fault <= FAULT_REF;
                st <= ST_OUT;
              end else begin
                st <= ST_SQRT_GO;
              end
            end else if (k == K_RY) begin
              st <= ST_SQRT_GO;
            end else if (k > K_RY) begin
              st <= ST_IDLE;
            end else begin
              k <= k + 1'b1;
              st <= ST_MUL_GO;
            end
          end
        end
        ST_SQRT_GO: st <= ST_SQRT_WAIT;
        ST_SQRT_WAIT: begin
          if (sqrt_done) begin
            if (!sq_rho) begin
              m <= root[39:0];
              em <= 41'(en) + {1'b0, root[39:0]};
              st <= ST_MUL_GO;
            end else begin
              if (bv[2] < 0) begin
                ux <= {23'b0, root};
                uy <= -64'(bv[2]);
                acc <= ACC_RIGHT;
              end else begin
                ux <= 64'(bv[2]);
                uy <= {23'b0, root};
                acc <= '0;
              end
              st <= ST_NORM;
            end
          end
        end
        ST_DIV_GO: st <= ST_DIV_WAIT;
        ST_DIV_WAIT: begin
          if (div_done) begin
            if (div_e) begin
              res.boosted_energy <= be_new;
              if (bv[0] == '0 && bv[1] == '0 && bv[2] == '0) begin
                res.fault <= FAULT_ZERO;
                st <= ST_OUT;
              end else begin
                k <= K_RX;
                st <= ST_MUL_GO;
              end
            end else begin
              case (k)
                K_BX: begin bv[0] <= b_new; res.boosted_px <= b_new; end
                K_BY: begin bv[1] <= b_new; res.boosted_py <= b_new; end
                default: begin bv[2] <= b_new; res.boosted_pz <= b_new; end
              endcase
              if (k == K_BZ) begin
                div_e <= 1'b1;
                nneg <= nn[81];
                dn <= {47'b0, nn_mag};
                dd <= {42'b0, m};
                st <= ST_DIV_GO;
              end else begin
                k <= k + 1'b1;
                st <= ST_MUL_GO;
              end
            end
          end
        end
        ST_NORM: begin
          if (mx == '0 || mx >= NORM_LIM) begin
            cx <= $signed(ux);
            cy <= $signed(uy);
            ci <= '0;
            st <= ST_CORD;
          end else begin
            ux <= ux << 1;
            uy <= uy << 1;
          end
        end
        ST_CORD: begin
          if (cy > 0) begin
            cx <= cx + cdx;
            cy <= cy - cdy;
            acc <= acc + $signed({2'b0, atan_v});
          end else begin
            cx <= cx - cdx;
            cy <= cy + cdy;
            acc <= acc - $signed({2'b0, atan_v});
          end
          ci <= ci + 1'b1;
          if (ci == 5'(CORDIC_STEPS - 1)) begin
            st <= ST_ANG;
          end
        end
        ST_ANG: begin
          res.polar_angle <= angle;
          res.in_window <= (angle_low <= angle) && (angle <= angle_high);
          st <= ST_OUT;
        end
        ST_OUT: begin
          if (!result_out.valid || result_out.ready) begin
            st <= ST_IDLE;
          end
        end
        default: st <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_OUT && (!result_out.valid || result_out.ready)) begin
      result_out.payload <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (st == ST_OUT && (!result_out.valid || result_out.ready)) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

endmodule

@@ src/rfb_checker.sv @@
module rfb_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input rfb_pkg::out_item_t  out_item
);
  import rfb_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_window_fault: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.in_window |-> out_item.fault == FAULT_NONE)
    else $error("window flag set on a faulted item");

  a_ref_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.fault == FAULT_REF |->
      out_item.boosted_px == '0 && out_item.boosted_energy == '0 &&
      out_item.polar_angle == '0)
    else $error("non-timelike reference with nonzero result");

  a_zero_angle: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.fault == FAULT_ZERO |->
      out_item.polar_angle == '0 && out_item.boosted_px == '0 &&
      out_item.boosted_py == '0 && out_item.boosted_pz == '0)
    else $error("zero-length fault with nonzero momentum or angle");

endmodule

bind rest_frame_boost_angle_cut rfb_checker u_rfb_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_item  (result_out.payload)
);
